### hw/rtl/pisd_pkg.sv
package pisd_pkg;

    localparam int FRACTION_BITS  = 6;
    localparam int INTEGRAL_SHIFT = 3;

    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 15;
    localparam int DUTY_W  = 8;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIFF_W  = SUM_W + 1;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd254;
    localparam logic [DUTY_W-1:0] PWM_OFF  = 8'd255;

    localparam logic [GAIN_W-1:0] KP_RESET    = 15'd64;
    localparam logic [GAIN_W-1:0] KI_RESET    = 15'd192;
    localparam logic [GAIN_W-1:0] LIMIT_RESET = 15'd128;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_STOP = 2'd1,
        CMD_RUN  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_KP    = 2'd0,
        REG_KI    = 2'd1,
        REG_LIMIT = 2'd2,
        REG_NONE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic prod_load;
        logic ctl_load;
    } gain_ctl_t;

endpackage

### hw/rtl/pisd_gain_pipe.sv
module pisd_gain_pipe
    import pisd_pkg::*;
(
    input  logic                     clk,
    input  gain_ctl_t                en,
    input  logic        [GAIN_W-1:0] kp,
    input  logic        [GAIN_W-1:0] ki,
    input  logic signed [DATA_W-1:0] err,
    input  logic signed [DATA_W-1:0] acc,
    output logic signed [SUM_W-1:0]  ctl
);

    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_p_next;
    logic signed [PROD_W-1:0] prod_i_next;
    logic signed [PROD_W-1:0] p_sh;
    logic signed [PROD_W-1:0] i_sh;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  ctl_reg;
    logic signed [SUM_W-1:0]  ctl_next;

    // Both gains are unsigned, so a zero sign bit makes the multiply signed.
    assign prod_p_next = $signed({1'b0, kp}) * err;
    assign prod_i_next = $signed({1'b0, ki}) * acc;

    assign p_sh     = prod_p_reg >>> FRACTION_BITS;
    assign i_sh     = prod_i_reg >>> FRACTION_BITS;
    assign sum      = {p_sh[PROD_W-1], p_sh} + {i_sh[PROD_W-1], i_sh};
    assign ctl_next = sum >>> FRACTION_BITS;

    always_ff @(posedge clk)
    begin
        if (en.prod_load)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
        if (en.ctl_load)
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl = ctl_reg;

endmodule

### hw/rtl/pi_speed_duty_controller_unit.sv
// Throughput: one request per cycle unless the output stalls, through a five-register
// pipeline (input, integrator, gain products, control sum, duty and result register);
// stages with bubbles keep moving.
// Reset is asynchronous and active low: the integral clears, the duty level goes to 255,
// the motor is stopped, the gains and limit take their reset values and the pipeline empties.
module pi_speed_duty_controller_unit
    import pisd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               command,
    input  logic [DATA_W-1:0]        setpoint,
    input  logic [DATA_W-1:0]        measured_speed,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DUTY_W-1:0]        pwm_compare,
    output logic signed [DATA_W-1:0] integral_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data
);

    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] limit_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv_out;

    logic                     stopped_reg;
    logic                     stopped_next;
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] integral_next;
    logic [DUTY_W-1:0]        duty_reg;
    logic [DUTY_W-1:0]        duty_next;
    logic                     duty_load;

    cmd_t              cmd_s1_reg;
    logic [DATA_W-1:0] sp_s1_reg;
    logic [DATA_W-1:0] ms_s1_reg;

    cmd_t                     cmd_s2_reg, cmd_s3_reg, cmd_s4_reg;
    logic                     stop_s2_reg, stop_s3_reg, stop_s4_reg;
    logic signed [DATA_W-1:0] err_s2_reg;
    logic signed [DATA_W-1:0] acc_s2_reg, acc_s3_reg, acc_s4_reg;

    logic [DUTY_W-1:0]        pwm_reg;
    logic [DUTY_W-1:0]        pwm_next;
    logic signed [DATA_W-1:0] int_out_reg;

    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] err_sh;
    logic signed [DATA_W:0]   acc_sum;
    logic signed [DATA_W:0]   lim;
    logic signed [DATA_W:0]   neg_lim;
    logic signed [DATA_W-1:0] acc_clamped;

    logic signed [SUM_W-1:0]  ctl;
    logic signed [DIFF_W-1:0] duty_diff;
    gain_ctl_t                gain_en;

    // Each stage moves when it is empty or when the stage after it moves.
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv4     = !v4_reg || adv_out;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)    v1_reg        <= in_valid;
            if (adv2)    v2_reg        <= v1_reg;
            if (adv3)    v3_reg        <= v2_reg;
            if (adv4)    v4_reg        <= v3_reg;
            if (adv_out) out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= KP_RESET;
            ki_reg    <= KI_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:    kp_reg    <= cfg_data;
                REG_KI:    ki_reg    <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data;
                REG_NONE:  ;
            endcase
        end
    end

    // Integrator stage.
    assign err     = $signed(sp_s1_reg - ms_s1_reg);
    assign err_sh  = err >>> INTEGRAL_SHIFT;
    assign lim     = $signed({2'b00, limit_reg});
    assign neg_lim = -lim;

    always_comb
    begin
        acc_sum = {integral_reg[DATA_W-1], integral_reg};
        if (!stopped_reg)
        begin
            acc_sum = acc_sum + {err_sh[DATA_W-1], err_sh};
        end
        priority if (acc_sum > lim)
        begin
            acc_clamped = lim[DATA_W-1:0];
        end
        else if (acc_sum < neg_lim)
        begin
            acc_clamped = neg_lim[DATA_W-1:0];
        end
        else
        begin
            acc_clamped = acc_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        integral_next = integral_reg;
        stopped_next  = stopped_reg;
        unique case (cmd_s1_reg)
            CMD_TICK: integral_next = acc_clamped;
            CMD_STOP:
            begin
                integral_next = '0;
                stopped_next  = 1'b1;
            end
            CMD_RUN:  stopped_next = 1'b0;
            CMD_NOP:  ;
        endcase
    end

    assign gain_en.prod_load = adv3;
    assign gain_en.ctl_load  = adv4;

    pisd_gain_pipe u_gain_pipe (
        .clk (clk),
        .en  (gain_en),
        .kp  (kp_reg),
        .ki  (ki_reg),
        .err (err_s2_reg),
        .acc (acc_s2_reg),
        .ctl (ctl)
    );

    // Duty update and result selection.
    assign duty_diff = $signed({{(DIFF_W-DUTY_W){1'b0}}, duty_reg}) - {ctl[SUM_W-1], ctl};

    always_comb
    begin
        priority if (duty_diff < 0)
        begin
            duty_next = '0;
        end
        else if (duty_diff > $signed({{(DIFF_W-DUTY_W){1'b0}}, DUTY_MAX}))
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = duty_diff[DUTY_W-1:0];
        end
    end

    always_comb
    begin
        duty_load = 1'b0;
        pwm_next  = PWM_OFF;
        unique case (cmd_s4_reg)
            CMD_TICK:
            begin
                if (!stop_s4_reg)
                begin
                    duty_load = 1'b1;
                    pwm_next  = duty_next;
                end
            end
            CMD_STOP: pwm_next = PWM_OFF;
            CMD_RUN:  pwm_next = stop_s4_reg ? PWM_OFF : duty_reg;
            CMD_NOP:  pwm_next = stop_s4_reg ? PWM_OFF : duty_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg  <= 1'b1;
            integral_reg <= '0;
            duty_reg     <= PWM_OFF;
        end
        else
        begin
            if (v1_reg && adv2)
            begin
                stopped_reg  <= stopped_next;
                integral_reg <= integral_next;
            end
            if (v4_reg && adv_out && duty_load)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cmd_s1_reg <= cmd_t'(command);
            sp_s1_reg  <= setpoint;
            ms_s1_reg  <= measured_speed;
        end
        if (adv2)
        begin
            cmd_s2_reg  <= cmd_s1_reg;
            stop_s2_reg <= stopped_reg;
            err_s2_reg  <= err;
            acc_s2_reg  <= integral_next;
        end
        if (adv3)
        begin
            cmd_s3_reg  <= cmd_s2_reg;
            stop_s3_reg <= stop_s2_reg;
            acc_s3_reg  <= acc_s2_reg;
        end
        if (adv4)
        begin
            cmd_s4_reg  <= cmd_s3_reg;
            stop_s4_reg <= stop_s3_reg;
            acc_s4_reg  <= acc_s3_reg;
        end
        if (adv_out)
        begin
            pwm_reg     <= pwm_next;
            int_out_reg <= acc_s4_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pwm_compare    = pwm_reg;
    assign integral_value = int_out_reg;

endmodule

### hw/rtl/pisd_checker.sv
module pisd_checker
    import pisd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [1:0]               command,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [DUTY_W-1:0]        pwm_compare,
    input logic signed [DATA_W-1:0] integral_value,
    input logic                     cfg_valid,
    input logic                     cfg_ready
);

    // A result held back by the consumer must stay in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pwm_compare)
            && $stable(integral_value))
        else $error("stalled result changed");

    // With nothing waiting at the output the whole pipeline is free to move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output");

    // The clamp is symmetric, so the most negative code can never appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> integral_value != 16'sh8000)
        else $error("integral outside the clamp range");

    // A stop request that meets no output stall on its way reports the motor off and a cleared integral.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_STOP) ##1 !out_stall ##1 !out_stall
            ##1 !out_stall ##1 !out_stall
        |=> out_valid && pwm_compare == PWM_OFF && integral_value == 0)
        else $error("stop request result wrong or late");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind pi_speed_duty_controller_unit pisd_checker u_pisd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pwm_compare    (pwm_compare),
    .integral_value (integral_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
);

### bench/pi_speed_duty_controller_unit_test.sv
`timescale 1ns / 1ps

module pi_speed_duty_controller_unit_test;
    import pisd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 75;

    typedef struct {
        logic [DUTY_W-1:0]        pwm;
        logic signed [DATA_W-1:0] integ;
    } duty_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               command;
    logic [DATA_W-1:0]        setpoint;
    logic [DATA_W-1:0]        measured_speed;
    logic                     out_valid;
    logic                     out_stall;
    logic [DUTY_W-1:0]        pwm_compare;
    logic signed [DATA_W-1:0] integral_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [GAIN_W-1:0]        cfg_data;

    logic [GAIN_W-1:0] gain_kp    = KP_RESET;
    logic [GAIN_W-1:0] gain_ki    = KI_RESET;
    logic [GAIN_W-1:0] gain_limit = LIMIT_RESET;
    longint            loop_integral = 0;
    longint            loop_duty     = 255;
    bit                loop_stopped  = 1'b1;

    duty_result_t expected_duty_q[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           stall_left     = 0;
    bit           tx_idling      = 1'b1;
    bit           rx_idling      = 1'b1;
    bit           hold_request   = 1'b0;

    pi_speed_duty_controller_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .setpoint       (setpoint),
        .measured_speed (measured_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pwm_compare    (pwm_compare),
        .integral_value (integral_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic duty_result_t advance_speed_loop(input cmd_t cmd,
                                                        input logic [DATA_W-1:0] sp,
                                                        input logic [DATA_W-1:0] ms);
        logic [DATA_W-1:0] diff;
        longint            err;
        longint            acc;
        longint            lim;
        longint            ctl;
        longint            next_duty;
        duty_result_t      r;
        r.pwm = PWM_OFF;
        case (cmd)
            CMD_TICK:
            begin
                diff = sp - ms;
                err  = longint'($signed(diff));
                lim  = longint'(gain_limit);
                acc  = loop_integral;
                if (!loop_stopped)
                    acc = acc + (err >>> INTEGRAL_SHIFT);
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim)
                    acc = -lim;
                loop_integral = acc;
                ctl = ((longint'(gain_kp) * err) >>> FRACTION_BITS)
                    + ((longint'(gain_ki) * acc) >>> FRACTION_BITS);
                ctl = ctl >>> FRACTION_BITS;
                if (!loop_stopped)
                begin
                    next_duty = loop_duty - ctl;
                    if (next_duty < 0)
                        next_duty = 0;
                    else if (next_duty > longint'(DUTY_MAX))
                        next_duty = longint'(DUTY_MAX);
                    loop_duty = next_duty;
                    r.pwm = loop_duty[DUTY_W-1:0];
                end
            end
            CMD_STOP:
            begin
                loop_stopped  = 1'b1;
                loop_integral = 0;
            end
            CMD_RUN:
            begin
                if (!loop_stopped)
                    r.pwm = loop_duty[DUTY_W-1:0];
                loop_stopped = 1'b0;
            end
            default:
            begin
                if (!loop_stopped)
                    r.pwm = loop_duty[DUTY_W-1:0];
            end
        endcase
        r.integ = loop_integral[DATA_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : duty_scoreboard
        duty_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_duty_q.size() == 0)
                begin
                    $display("%0t: unexpected result pwm_compare=%0d integral_value=%0d",
                             $time, pwm_compare, integral_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (pwm_compare !== want.pwm)
                    begin
                        $display("%0t: pwm_compare expected %0d actual %0d",
                                 $time, want.pwm, pwm_compare);
                        mismatch_count++;
                    end
                    if (integral_value !== want.integ)
                    begin
                        $display("%0t: integral_value expected %0d actual %0d",
                                 $time, want.integ, integral_value);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_KP:    gain_kp    = cfg_data;
                    REG_KI:    gain_ki    = cfg_data;
                    REG_LIMIT: gain_limit = cfg_data;
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_duty_q.push_back(advance_speed_loop(cmd_t'(command), setpoint,
                                                             measured_speed));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("pi_speed_duty_controller_unit_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin : output_stall_driver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_request(input cmd_t cmd, input logic [DATA_W-1:0] sp,
                                input logic [DATA_W-1:0] ms);
        int gap;
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        setpoint       <= sp;
        measured_speed <= ms;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_request();
        int                pick;
        cmd_t              cmd;
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] ms;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            cmd = CMD_TICK;
        else if (pick < 88)
            cmd = CMD_RUN;
        else if (pick < 95)
            cmd = CMD_STOP;
        else
            cmd = CMD_NOP;
        ms = DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            sp = DATA_W'($urandom);
        else
            sp = ms + DATA_W'($urandom_range(0, 2047)) - 16'd1024;
        send_request(cmd, sp, ms);
    endtask

    task automatic run_burst(input int count);
        send_request(CMD_RUN, DATA_W'($urandom), DATA_W'($urandom));
        repeat (count) send_random_request();
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_duty_q.size() != 0);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [GAIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] lim);
        wait_for_results();
        write_register(REG_KP, kp);
        write_register(REG_KI, ki);
        write_register(REG_LIMIT, lim);
    endtask

    task automatic test_directed_commands();
        send_request(CMD_NOP, 16'h0000, 16'h0000);
        send_request(CMD_TICK, 16'd1000, 16'h0000);
        send_request(CMD_RUN, 16'hFFFF, 16'hFFFF);
        send_request(CMD_RUN, 16'h0000, 16'h0000);
        send_request(CMD_TICK, 16'd500, 16'd500);
        send_request(CMD_TICK, 16'h0000, 16'hFFFF);
        send_request(CMD_TICK, 16'hFFFF, 16'h0000);
        send_request(CMD_TICK, 16'h8000, 16'h0000);
        send_request(CMD_TICK, 16'h7FFF, 16'h0000);
        send_request(CMD_TICK, 16'h0000, 16'h8000);
        send_request(CMD_TICK, 16'hFFFF, 16'hFFFF);
        send_request(CMD_TICK, 16'h0000, 16'h7FFF);
        send_request(CMD_NOP, 16'hFFFF, 16'h0000);
        send_request(CMD_STOP, 16'hFFFF, 16'hFFFF);
        send_request(CMD_TICK, 16'h4000, 16'h0100);
        send_request(CMD_NOP, 16'h0000, 16'h0000);
        send_request(CMD_RUN, 16'h0000, 16'h0000);
        send_request(CMD_TICK, 16'h0200, 16'h0100);
        send_request(CMD_TICK, 16'h0100, 16'h0200);
    endtask

    task automatic test_gain_extremes();
        set_gains(15'd0, 15'd0, 15'd0);
        run_burst(20);
        set_gains(15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_burst(20);
        set_gains(15'h7FFF, 15'd0, 15'h7FFF);
        run_burst(20);
        set_gains(15'd0, 15'h7FFF, 15'd1);
        run_burst(20);
        wait_for_results();
        write_register(REG_NONE, 15'h7FFF);
        run_burst(10);
    endtask

    task automatic test_integral_limit_change();
        set_gains(KP_RESET, KI_RESET, 15'h7FFF);
        send_request(CMD_RUN, 16'h0000, 16'h0000);
        repeat (8) send_request(CMD_TICK, 16'd9000, 16'd5000);
        wait_for_results();
        write_register(REG_LIMIT, 15'd100);
        send_request(CMD_TICK, 16'd5000, 16'd5000);
        send_request(CMD_TICK, 16'd1000, 16'd9000);
        send_request(CMD_TICK, 16'd1000, 16'd9000);
        set_gains(KP_RESET, KI_RESET, LIMIT_RESET);
    endtask

    task automatic test_output_hold();
        tx_idling    = 1'b0;
        hold_request = 1'b1;
        run_burst(40);
        tx_idling = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_burst(10);
        wait_for_results();
        run_burst(10);
    endtask

    task automatic test_random_phases();
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] lim;
        for (int phase = 0; phase < 6; phase++)
        begin
            kp  = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 511));
            ki  = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 511));
            lim = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
                                               : GAIN_W'($urandom_range(0, 4095));
            set_gains(kp, ki, lim);
            // The last phase runs with both sides busy on every cycle.
            tx_idling = (phase < 5) && (phase % 3 != 2);
            rx_idling = (phase < 5) && (phase % 3 != 1);
            run_burst(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= CMD_NOP;
        setpoint       <= '0;
        measured_speed <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_NONE;
        cfg_data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_gain_extremes();
        test_integral_limit_change();
        test_output_hold();
        test_sender_pause();
        test_random_phases();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("pi_speed_duty_controller_unit_test OK");
        else
            $display("pi_speed_duty_controller_unit_test NOT OK");
        $finish;
    end

endmodule
